@@ hdl/sbba_pkg.sv @@
// Package for the segregated-bin bump allocator: payload structs, command and
// status structs between controller and datapath, codes and size helpers.
// No dependencies.
`timescale 1ns / 1ps

package sbba_pkg;

   // Geometry
   localparam int NUM_BINS       = 511;
   localparam int CLASS_BYTES    = 64;
   localparam int HEAP_ADDR_BITS = 20;
   localparam int GRANULE_BYTES  = 16;
   localparam int PAGE_BYTES     = 4096;
   localparam int HDR_BYTES      = 8;

   localparam int CLASS_W   = $clog2(NUM_BINS);
   localparam int CLASS_SH  = $clog2(CLASS_BYTES);
   localparam int GRAN_SH   = $clog2(GRANULE_BYTES);
   localparam int PAGE_SH   = $clog2(PAGE_BYTES);
   localparam int GRAN_W    = HEAP_ADDR_BITS - GRAN_SH;
   localparam int LINK_W    = GRAN_W + 1;
   localparam int ADDR_W    = 20;
   localparam int SIZE_W    = 21;
   localparam int PTR_W     = 22;
   localparam int CSR_W     = 21;
   localparam int SMALL_LIMIT = NUM_BINS * CLASS_BYTES;
   localparam int HEAP_SPAN   = 1 << HEAP_ADDR_BITS;

   // Reset values of the registers
   localparam logic [SIZE_W-1:0] HEAP_START_RST = SIZE_W'(4096);
   localparam logic [SIZE_W-1:0] HEAP_END_RST   = SIZE_W'(1048576);

   // Operation codes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_ALIGNED = 2'd2;

   // Status codes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_OOM       = 2'd1;
   localparam logic [1:0] STS_BAD_ALIGN = 2'd2;
   localparam logic [1:0] STS_NULL_FREE = 2'd3;

   // Register indexes
   localparam logic CSR_HEAP_START = 1'b0;
   localparam logic CSR_HEAP_END   = 1'b1;

   typedef struct packed {
      logic [1:0]        op;
      logic [SIZE_W-1:0] req_size;
      logic [ADDR_W-1:0] block_addr;
      logic [ADDR_W-1:0] align_bytes;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_addr;
      logic [1:0]        status;
      logic [SIZE_W-1:0] release_start;
      logic [SIZE_W-1:0] release_length;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;     // latch request, preset result
      logic clear_wr;     // clear one bin head
      logic rd_head_in;   // read bin head of incoming size class
      logic free_small;   // read bin head of stored size class
      logic head_pop;     // read link of head block, result = head
      logic link_write;   // bin head <= link
      logic bump_calc;    // align bump pointer
      logic bump_commit;  // place block or flag out of memory
      logic rd_size;      // read size header of freed block
      logic free_push;    // push freed block onto its bin
      logic free_release; // compute released page range
      logic load_rsp;     // move result into output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] in_op;
      logic       in_small;
      logic       in_bad_align;
      logic       in_null;
      logic       head_valid;
      logic       size_small;
      logic       clear_last;
   } stat_type;

   // Size class: size 0 is class 0, large sizes clamp to the last class
   function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0]          m;
      logic [SIZE_W-CLASS_SH-1:0] c;
      begin
         m = size - SIZE_W'(1);
         c = m[SIZE_W-1:CLASS_SH];
         if (size == '0) begin
            class_of = '0;
         end else if (c >= (SIZE_W-CLASS_SH)'(NUM_BINS - 1)) begin
            class_of = CLASS_W'(NUM_BINS - 1);
         end else begin
            class_of = CLASS_W'(c);
         end
      end
   endfunction

endpackage

@@ hdl/sbba_ctrl.sv @@
// Controller of the segregated-bin bump allocator: sequences bin clearing,
// list pops and pushes, bump placement and the output register.
// Depends on sbba_pkg.
`timescale 1ns / 1ps

module sbba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  sbba_pkg::stat_type stat,
   output sbba_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HEAD  = 4'd2;
   localparam logic [3:0] S_LINK  = 4'd3;
   localparam logic [3:0] S_BUMP1 = 4'd4;
   localparam logic [3:0] S_BUMP2 = 4'd5;
   localparam logic [3:0] S_FSIZE = 4'd6;
   localparam logic [3:0] S_FHEAD = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               case (stat.in_op)
                  sbba_pkg::OP_ALLOC: begin
                     if (stat.in_small) begin
                        cmd.rd_head_in = 1'b1;
                        state_in = S_HEAD;
                     end else begin
                        state_in = S_BUMP1;
                     end
                  end
                  sbba_pkg::OP_FREE: begin
                     if (stat.in_null) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.rd_size = 1'b1;
                        state_in = S_FSIZE;
                     end
                  end
                  sbba_pkg::OP_ALIGNED: begin
                     state_in = stat.in_bad_align ? S_DONE : S_BUMP1;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_HEAD: begin
            if (stat.head_valid) begin
               cmd.head_pop = 1'b1;
               state_in = S_LINK;
            end else begin
               state_in = S_BUMP1;
            end
         end
         S_LINK: begin
            cmd.link_write = 1'b1;
            state_in = S_DONE;
         end
         S_BUMP1: begin
            cmd.bump_calc = 1'b1;
            state_in = S_BUMP2;
         end
         S_BUMP2: begin
            cmd.bump_commit = 1'b1;
            state_in = S_DONE;
         end
         S_FSIZE: begin
            if (stat.size_small) begin
               cmd.free_small = 1'b1;
               state_in = S_FHEAD;
            end else begin
               cmd.free_release = 1'b1;
               state_in = S_DONE;
            end
         end
         S_FHEAD: begin
            cmd.free_push = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output beat valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Memory writes never collide
   a_write_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.link_write, cmd.bump_commit, cmd.free_push}))
      else $error("sbba_ctrl: colliding memory writes");

   // Result never overwrites a beat still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> slot_free)
      else $error("sbba_ctrl: output beat overwritten");

   // A new beat appears only after a finished request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("sbba_ctrl: output beat without request");

   // No request taken while bins are being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !cmd.load_req && !rsp_valid_ff)
      else $error("sbba_ctrl: activity during bin clear");

endmodule

@@ hdl/sbba_dp.sv @@
// Datapath of the segregated-bin bump allocator: request and result
// registers, bump pointer, bin head, size header and link memories.
// Depends on sbba_pkg.
`timescale 1ns / 1ps

module sbba_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  sbba_pkg::req_type           req_payload,
   output sbba_pkg::rsp_type           rsp_payload,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [sbba_pkg::CSR_W-1:0]  csr_wdata,
   input  sbba_pkg::cmd_type           cmd,
   output sbba_pkg::stat_type          stat
);

   localparam int CW = sbba_pkg::CLASS_W;
   localparam int GW = sbba_pkg::GRAN_W;
   localparam int LW = sbba_pkg::LINK_W;
   localparam int SW = sbba_pkg::SIZE_W;
   localparam int AW = sbba_pkg::ADDR_W;
   localparam int PW = sbba_pkg::PTR_W;
   localparam int GS = sbba_pkg::GRAN_SH;
   localparam int PS = sbba_pkg::PAGE_SH;

   // Memories
   logic [LW-1:0] heads_mem [0:sbba_pkg::NUM_BINS-1];
   logic [SW-1:0] sizes_mem [0:(1 << GW)-1];
   logic [LW-1:0] links_mem [0:(1 << GW)-1];

   // Registers
   logic [1:0]    op_ff;
   logic [SW-1:0] size_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] align_ff;
   logic [CW-1:0] class_ff;
   logic [CW-1:0] clr_cnt_ff;
   logic [SW-1:0] bump_ff;
   logic [SW-1:0] heap_end_ff;
   logic [PW-1:0] place_ff, place_in;
   logic [LW-1:0] head_q_ff;
   logic [LW-1:0] link_q_ff;
   logic [SW-1:0] size_q_ff;
   logic [AW-1:0] res_addr_ff;
   logic [1:0]    res_status_ff;
   logic [SW-1:0] res_start_ff;
   logic [SW-1:0] res_len_ff;
   sbba_pkg::rsp_type rsp_ff;

   logic [CW-1:0] in_class, sz_class, head_rd_addr;
   logic          in_bad;
   logic [SW-1:0] round_size, bump_size, end_eff;
   logic [AW-1:0] align_eff, align_mask;
   logic          oom;
   logic [SW-1:0] page_off, rel_len, rel_len_pg, rel_start;
   logic [GW-1:0] free_gran;

   // Decode the incoming beat
   assign in_class = sbba_pkg::class_of(req_payload.req_size);
   assign in_bad   = (req_payload.align_bytes == '0) ||
                     ((req_payload.align_bytes & (req_payload.align_bytes - AW'(1))) != '0);
   assign sz_class = sbba_pkg::class_of(size_q_ff);

   assign stat.in_op        = req_payload.op;
   assign stat.in_small     = req_payload.req_size < SW'(sbba_pkg::SMALL_LIMIT);
   assign stat.in_bad_align = in_bad;
   assign stat.in_null      = (req_payload.block_addr == '0);
   assign stat.head_valid   = head_q_ff[LW-1];
   assign stat.size_small   = size_q_ff < SW'(sbba_pkg::SMALL_LIMIT);
   assign stat.clear_last   = (clr_cnt_ff == CW'(sbba_pkg::NUM_BINS - 1));

   // Block size and alignment for bump placement
   assign round_size = SW'({1'b0, class_ff} + (CW+1)'(1)) << sbba_pkg::CLASS_SH;
   assign bump_size  = (size_ff < SW'(sbba_pkg::SMALL_LIMIT)) ? round_size : size_ff;
   assign align_eff  = ((op_ff == sbba_pkg::OP_ALIGNED) &&
                        (align_ff > AW'(sbba_pkg::GRANULE_BYTES))) ?
                       align_ff : AW'(sbba_pkg::GRANULE_BYTES);
   assign align_mask = align_eff - AW'(1);
   assign place_in   = (PW'(bump_ff) + PW'(sbba_pkg::HDR_BYTES) + PW'(align_mask)) &
                       ~PW'(align_mask);
   assign end_eff    = (heap_end_ff > SW'(sbba_pkg::HEAP_SPAN)) ?
                       SW'(sbba_pkg::HEAP_SPAN) : heap_end_ff;
   assign oom        = ((place_ff + PW'(bump_size)) > PW'(end_eff)) || (place_ff == '0);

   // Released page range of a large free
   assign page_off   = SW'(addr_ff[PS-1:0]);
   assign rel_len    = (page_off > size_q_ff) ? '0 : (size_q_ff - page_off);
   assign rel_len_pg = {rel_len[SW-1:PS], {PS{1'b0}}};
   assign rel_start  = (SW'(addr_ff) + SW'(sbba_pkg::PAGE_BYTES - 1)) &
                       ~SW'(sbba_pkg::PAGE_BYTES - 1);
   assign free_gran  = addr_ff[AW-1:GS];

   assign head_rd_addr = cmd.free_small ? sz_class : in_class;

   // Control registers: clear counter, bump pointer, heap end
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         bump_ff     <= sbba_pkg::HEAP_START_RST;
         heap_end_ff <= sbba_pkg::HEAP_END_RST;
      end else begin
         if (cmd.clear_wr) clr_cnt_ff <= clr_cnt_ff + CW'(1);
         if (csr_wr_en && csr_index == sbba_pkg::CSR_HEAP_START) begin
            bump_ff <= {1'b0, csr_wdata[AW-1:0]};
         end else if (cmd.bump_commit && !oom) begin
            bump_ff <= SW'(place_ff + PW'(bump_size));
         end
         if (csr_wr_en && csr_index == sbba_pkg::CSR_HEAP_END) begin
            heap_end_ff <= csr_wdata;
         end
      end
   end

   // Request and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff         <= req_payload.op;
         size_ff       <= req_payload.req_size;
         addr_ff       <= req_payload.block_addr;
         align_ff      <= req_payload.align_bytes;
         class_ff      <= in_class;
         res_addr_ff   <= '0;
         res_start_ff  <= '0;
         res_len_ff    <= '0;
         if (req_payload.op == sbba_pkg::OP_ALIGNED && in_bad) begin
            res_status_ff <= sbba_pkg::STS_BAD_ALIGN;
         end else if (req_payload.op == sbba_pkg::OP_FREE &&
                      req_payload.block_addr == '0) begin
            res_status_ff <= sbba_pkg::STS_NULL_FREE;
         end else begin
            res_status_ff <= sbba_pkg::STS_OK;
         end
      end
      if (cmd.free_small) class_ff <= sz_class;
      if (cmd.bump_calc) place_ff <= place_in;
      if (cmd.head_pop) res_addr_ff <= {head_q_ff[GW-1:0], {GS{1'b0}}};
      if (cmd.bump_commit) begin
         if (oom) begin
            res_status_ff <= sbba_pkg::STS_OOM;
            res_addr_ff   <= '0;
         end else begin
            res_addr_ff   <= place_ff[AW-1:0];
         end
      end
      if (cmd.free_release && rel_len_pg != '0) begin
         res_len_ff   <= rel_len_pg;
         res_start_ff <= rel_start;
      end
      if (cmd.load_rsp) begin
         rsp_ff.result_addr    <= res_addr_ff;
         rsp_ff.status         <= res_status_ff;
         rsp_ff.release_start  <= res_start_ff;
         rsp_ff.release_length <= res_len_ff;
      end
   end

   // Bin head memory
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         heads_mem[clr_cnt_ff] <= '0;
      end else if (cmd.link_write) begin
         heads_mem[class_ff] <= link_q_ff;
      end else if (cmd.free_push) begin
         heads_mem[class_ff] <= {1'b1, free_gran};
      end
      if (cmd.rd_head_in || cmd.free_small) head_q_ff <= heads_mem[head_rd_addr];
   end

   // Link memory
   always_ff @(posedge clock) begin
      if (cmd.free_push) links_mem[free_gran] <= head_q_ff;
      if (cmd.head_pop) link_q_ff <= links_mem[head_q_ff[GW-1:0]];
   end

   // Size header memory
   always_ff @(posedge clock) begin
      if (cmd.bump_commit && !oom) sizes_mem[place_ff[AW-1:GS]] <= bump_size;
      if (cmd.rd_size) size_q_ff <= sizes_mem[req_payload.block_addr[AW-1:GS]];
   end

   assign rsp_payload = rsp_ff;

endmodule

@@ hdl/segregated_bin_bump_allocator_top.sv @@
// Segregated-bin bump allocator, top level: joins controller and datapath.
// The result beat is slowest for a small allocate that misses its list (bin head
// read, then bump align and place); a stalled output can hold it back further.
// One request is in flight at a time; the next is taken once its result is loaded.
// Reset: synchronous; afterwards a pass clears all 511 bin heads, and no
// request is taken until it ends. Register writes are taken during the pass.
`timescale 1ns / 1ps

module segregated_bin_bump_allocator_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sbba_pkg::req_type          req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sbba_pkg::rsp_type          rsp_payload,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [sbba_pkg::CSR_W-1:0] csr_wdata
);

   sbba_pkg::cmd_type  cmd;
   sbba_pkg::stat_type stat;

   sbba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sbba_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
